// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, field widths and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

   // Operand numerator width; the denominator is one bit narrower.
   localparam int OPERAND_WIDTH = 16;
   localparam int DEN_W         = OPERAND_WIDTH - 1;

   // Products, signed sums and their magnitudes.
   localparam int PROD_W = 2 * OPERAND_WIDTH;
   localparam int NUM_W  = 2 * OPERAND_WIDTH + 1;
   localparam int MAG_W  = 2 * OPERAND_WIDTH;

   // Shift count of the GCD and step count of the divider.
   localparam int STEP_W = $clog2(MAG_W);

   // Result field widths.
   localparam int RES_NUM_W = 32;
   localparam int RES_DEN_W = 31;

   // Operation codes.
   localparam int KIND_W = 4;
   localparam logic [KIND_W-1:0] KIND_ADD = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 4'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 4'd3;
   localparam logic [KIND_W-1:0] KIND_NEG = 4'd4;
   localparam logic [KIND_W-1:0] KIND_LT  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_GT  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_LE  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_GE  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_EQ  = 4'd9;
   localparam logic [KIND_W-1:0] KIND_NE  = 4'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic multiply;
      logic prepare;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic publish;
   } rau_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
      logic gcd_done;
   } rau_status_type;

endpackage

// File: rtl/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing controller
// Steps one transaction through multiply, prepare, GCD, divide and finish,
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module rau_ctrl
   import rau_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  rau_status_type status,
   output rau_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_GCD    = 3'd3;
   localparam logic [2:0] ST_SHIFT  = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              valid_ff, valid_in;
   logic              out_free;

   // The result register can take a new result when empty or being drained.
   // No request is taken while reset is asserted.
   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_PREP;
         end
         ST_PREP: begin
            cmd.prepare = 1'b1;
            state_in    = ST_GCD;
         end
         ST_GCD: begin
            if (status.skip) begin
               state_in = ST_FINISH;
            end else if (status.gcd_done) begin
               state_in = ST_SHIFT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.div_init = 1'b1;
            count_in     = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result stays valid until the receiver takes it.
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (cmd.publish) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/rau_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand registers, cross multipliers, sign handling, a binary GCD unit,
// two restoring dividers and the result register.
// ----------------------------------------------------------------------------
module rau_dp
   import rau_pkg::*;
(
   input  logic                        clock,
   input  rau_cmd_type                 cmd,
   output rau_status_type              status,
   input  logic [KIND_W-1:0]           req_kind,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic [DEN_W-1:0]            req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic [DEN_W-1:0]            req_b_den,
   output logic signed [RES_NUM_W-1:0] rsp_res_num,
   output logic [RES_DEN_W-1:0]        rsp_res_den,
   output logic                        rsp_cmp_true,
   output logic                        rsp_error
);

   // Operand registers.
   logic [KIND_W-1:0]               kind_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff, bn_ff;
   logic [DEN_W-1:0]                ad_ff, bd_ff;

   // Product registers.
   logic signed [PROD_W-1:0] m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic signed [OPERAND_WIDTH:0] sel1, sel3, ad_s, bd_s;

   // Prepared values.
   logic signed [NUM_W-1:0] num_w, den_w;
   logic [MAG_W-1:0]        un_w, ud_w;
   logic                    arith_w, cmp_w;
   logic                    neg_ff, skip_ff, cmp_ff, err_ff;

   // GCD and divider registers.
   logic [MAG_W-1:0]  u_ff, u_in, v_ff, v_in, g_ff;
   logic [STEP_W-1:0] k_ff, k_in;
   logic [MAG_W-1:0]  rn_ff, rn_in, qn_ff, qn_in, rd_ff, rd_in, qd_ff, qd_in;
   logic [MAG_W-1:0]  un_ff, ud_ff;
   logic signed [MAG_W-1:0] sn_w;

   // One restoring division step: returns the new remainder and quotient.
   function automatic logic [2*MAG_W-1:0] div_step_f(
      input logic [MAG_W-1:0] rem,
      input logic [MAG_W-1:0] quo,
      input logic [MAG_W-1:0] dvs
   );
      logic [MAG_W:0] shifted;
      logic [MAG_W:0] diff;
      shifted = {rem, quo[MAG_W-1]};
      diff    = shifted - {1'b0, dvs};
      if (shifted >= {1'b0, dvs}) begin
         div_step_f = {diff[MAG_W-1:0], quo[MAG_W-2:0], 1'b1};
      end else begin
         div_step_f = {shifted[MAG_W-1:0], quo[MAG_W-2:0], 1'b0};
      end
   endfunction

   // Capture the operands of an accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         an_ff   <= req_a_num;
         ad_ff   <= req_a_den;
         bn_ff   <= req_b_num;
         bd_ff   <= req_b_den;
      end
   end

   // Cross multipliers; the second factors of the first and third follow the operation.
   always_comb begin
      ad_s  = signed'({2'b00, ad_ff});
      bd_s  = signed'({2'b00, bd_ff});
      sel1  = (kind_ff == KIND_MUL) ? signed'({bn_ff[OPERAND_WIDTH-1], bn_ff}) : bd_s;
      sel3  = (kind_ff == KIND_DIV) ? signed'({bn_ff[OPERAND_WIDTH-1], bn_ff}) : bd_s;
      m1_in = an_ff * sel1;
      m2_in = bn_ff * ad_s;
      m3_in = ad_s * sel3;
   end

   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
      end
   end

   // Form the signed numerator and denominator and the comparison flag.
   always_comb begin
      num_w   = '0;
      den_w   = NUM_W'(m3_ff);
      arith_w = 1'b1;
      cmp_w   = 1'b0;
      case (kind_ff)
         KIND_ADD: num_w = NUM_W'(m1_ff) + NUM_W'(m2_ff);
         KIND_SUB: num_w = NUM_W'(m1_ff) - NUM_W'(m2_ff);
         KIND_MUL, KIND_DIV: num_w = NUM_W'(m1_ff);
         KIND_NEG: begin
            num_w = -NUM_W'(an_ff);
            den_w = signed'(NUM_W'({1'b0, ad_ff}));
         end
         KIND_LT: begin arith_w = 1'b0; cmp_w = (m1_ff < m2_ff);  end
         KIND_GT: begin arith_w = 1'b0; cmp_w = (m1_ff > m2_ff);  end
         KIND_LE: begin arith_w = 1'b0; cmp_w = (m1_ff <= m2_ff); end
         KIND_GE: begin arith_w = 1'b0; cmp_w = (m1_ff >= m2_ff); end
         KIND_EQ: begin arith_w = 1'b0; cmp_w = (m1_ff == m2_ff); end
         KIND_NE: begin arith_w = 1'b0; cmp_w = (m1_ff != m2_ff); end
         default: arith_w = 1'b0;
      endcase
      un_w = num_w[NUM_W-1] ? MAG_W'(-num_w) : MAG_W'(num_w);
      ud_w = den_w[NUM_W-1] ? MAG_W'(-den_w) : MAG_W'(den_w);
   end

   // Binary GCD step: strip common and single factors of two, else subtract.
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = (u_ff - v_ff) >> 1;
      end else begin
         v_in = (v_ff - u_ff) >> 1;
      end
   end

   // Flags and GCD registers. Prepare also seeds the GCD unit.
   always_ff @(posedge clock) begin
      if (cmd.prepare) begin
         neg_ff  <= num_w[NUM_W-1] ^ den_w[NUM_W-1];
         skip_ff <= !arith_w || (den_w == '0);
         cmp_ff  <= cmp_w;
         err_ff  <= arith_w && (den_w == '0);
         u_ff    <= un_w;
         v_ff    <= ud_w;
         k_ff    <= '0;
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
   end

   // Dividends are the magnitudes kept from the prepare step.
   always_ff @(posedge clock) begin
      if (cmd.prepare) begin
         un_ff <= un_w;
         ud_ff <= ud_w;
      end
   end

   always_comb begin
      status.skip     = skip_ff;
      status.gcd_done = (u_ff == '0);
   end

   // Divider steps on numerator and denominator in parallel.
   always_comb begin
      {rn_in, qn_in} = div_step_f(rn_ff, qn_ff, g_ff);
      {rd_in, qd_in} = div_step_f(rd_ff, qd_ff, g_ff);
   end

   // The GCD is the odd part times two to the shared count.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         g_ff  <= v_ff << k_ff;
         rn_ff <= '0;
         rd_ff <= '0;
         qn_ff <= un_ff;
         qd_ff <= ud_ff;
      end else if (cmd.div_step) begin
         rn_ff <= rn_in;
         qn_ff <= qn_in;
         rd_ff <= rd_in;
         qd_ff <= qd_in;
      end
   end

   // Result register.
   assign sn_w = neg_ff ? signed'(-qn_ff) : signed'(qn_ff);

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         if (skip_ff) begin
            rsp_res_num <= '0;
            rsp_res_den <= RES_DEN_W'(1);
         end else begin
            rsp_res_num <= RES_NUM_W'(sn_w);
            rsp_res_den <= RES_DEN_W'(qd_ff);
         end
         rsp_cmp_true <= cmp_ff;
         rsp_error    <= err_ff;
      end
   end

endmodule

// File: rtl/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: rational number ALU with GCD reduction
// Adds, subtracts, multiplies, divides, negates or compares two signed
// fractions and returns the result reduced to lowest terms.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  req_     in         req_valid/req_stall  kind, a_num, a_den, b_num, b_den
//  rsp_     out        rsp_valid/rsp_stall  res_num, res_den, cmp_true, error
//
//  Comparisons, unused codes and errors pass from the multiply and prepare
//  steps straight to finish; arithmetic first runs the binary GCD loop and
//  the 32-step restoring dividers. The controller returns to its idle
//  state before the next transaction is accepted. One transaction is in
//  work at a time; the next one is accepted while the previous result
//  waits in the output register. Reset is synchronous and active high; it
//  clears the controller and the result valid flag and holds req_stall
//  high. A stalled result holds.
//
module rational_arithmetic_unit_top
   import rau_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [KIND_W-1:0]               req_kind,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic [DEN_W-1:0]                req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic [DEN_W-1:0]                req_b_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [RES_NUM_W-1:0]     rsp_res_num,
   output logic [RES_DEN_W-1:0]            rsp_res_den,
   output logic                            rsp_cmp_true,
   output logic                            rsp_error
);

   rau_cmd_type    cmd;
   rau_status_type status;

   // Controller.
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   rau_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .req_kind     (req_kind),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_cmp_true (rsp_cmp_true),
      .rsp_error    (rsp_error)
   );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of rational_arithmetic_unit_top
// Sends fraction operations over the request channel, predicts each reduced
// result or comparison flag in the testbench and checks every response field
// against it, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   import rau_pkg::*;

   // Highest code the kind field can carry; codes above KIND_NE are unused.
   localparam logic [KIND_W-1:0] KIND_LAST   = '1;
   localparam int                HOLD_CYCLES = 300;
   localparam int                TAIL_CYCLES = 150;

   // One expected response.
   typedef struct packed {
      logic signed [RES_NUM_W-1:0] num;
      logic [RES_DEN_W-1:0]        den;
      logic                        cmp;
      logic                        err;
   } rational_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [KIND_W-1:0]               req_kind = '0;
   logic signed [OPERAND_WIDTH-1:0] req_a_num = '0;
   logic [DEN_W-1:0]                req_a_den = '0;
   logic signed [OPERAND_WIDTH-1:0] req_b_num = '0;
   logic [DEN_W-1:0]                req_b_den = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic signed [RES_NUM_W-1:0]     rsp_res_num;
   logic [RES_DEN_W-1:0]            rsp_res_den;
   logic                            rsp_cmp_true;
   logic                            rsp_error;

   rational_result_type pending_results[$];
   int                  mismatch_count = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   logic                hold_req = 1'b0;
   logic                hold_seen;
   int                  hold_left;

   rational_arithmetic_unit_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_cmp_true (rsp_cmp_true),
      .rsp_error    (rsp_error)
   );

   always #4 clock = ~clock;

   // Computes the reduced fraction or comparison flag for one operation.
   function automatic rational_result_type rational_result(
      input logic [KIND_W-1:0]               kind,
      input logic signed [OPERAND_WIDTH-1:0] a_num,
      input logic [DEN_W-1:0]                a_den,
      input logic signed [OPERAND_WIDTH-1:0] b_num,
      input logic [DEN_W-1:0]                b_den);
      longint              an, ad, bn, bd, cross_a, cross_b, num, den;
      longint unsigned     mag_num, mag_den, gcd_a, gcd_b, rem;
      logic                negative;
      rational_result_type r;
      an      = a_num;
      ad      = a_den;
      bn      = b_num;
      bd      = b_den;
      cross_a = an * bd;
      cross_b = bn * ad;
      r.num   = '0;
      r.den   = RES_DEN_W'(1);
      r.cmp   = 1'b0;
      r.err   = 1'b0;
      num     = 0;
      den     = 1;
      case (kind)
         KIND_ADD: begin num = cross_a + cross_b; den = ad * bd; end
         KIND_SUB: begin num = cross_a - cross_b; den = ad * bd; end
         KIND_MUL: begin num = an * bn;           den = ad * bd; end
         KIND_DIV: begin num = an * bd;           den = ad * bn; end
         KIND_NEG: begin num = -an;               den = ad;      end
         KIND_LT: begin r.cmp = cross_a <  cross_b; return r; end
         KIND_GT: begin r.cmp = cross_a >  cross_b; return r; end
         KIND_LE: begin r.cmp = cross_a <= cross_b; return r; end
         KIND_GE: begin r.cmp = cross_a >= cross_b; return r; end
         KIND_EQ: begin r.cmp = cross_a == cross_b; return r; end
         KIND_NE: begin r.cmp = cross_a != cross_b; return r; end
         default: begin return r; end
      endcase
      // A zero denominator, from a zero divisor or a zero input denominator.
      if (den == 0) begin
         r.err = 1'b1;
         return r;
      end
      // Euclid's algorithm on the magnitudes, then the sign goes on top.
      mag_num = (num < 0) ? -num : num;
      mag_den = (den < 0) ? -den : den;
      gcd_a   = mag_num;
      gcd_b   = mag_den;
      while (gcd_b != 0) begin
         rem   = gcd_a % gcd_b;
         gcd_a = gcd_b;
         gcd_b = rem;
      end
      negative = (num < 0) != (den < 0);
      mag_num  = mag_num / gcd_a;
      mag_den  = mag_den / gcd_a;
      r.num    = RES_NUM_W'(negative ? -mag_num : mag_num);
      r.den    = RES_DEN_W'(mag_den);
      return r;
   endfunction

   // Random numerator, weighted toward extremes, zero and small values.
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_num();
      case ($urandom_range(9))
         0:       return {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
         1:       return {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
         2:       return '0;
         3, 4, 5: return OPERAND_WIDTH'($urandom_range(40) - 20);
         default: return OPERAND_WIDTH'($urandom);
      endcase
   endfunction

   // Random denominator; zero shows up now and then.
   function automatic logic [DEN_W-1:0] pick_den();
      case ($urandom_range(15))
         0:       return '0;
         1:       return DEN_W'(1);
         2:       return '1;
         3, 4, 5: return DEN_W'($urandom_range(12, 1));
         default: return DEN_W'($urandom_range((1 << DEN_W) - 1, 1));
      endcase
   endfunction

   // Offers one transaction, sometimes after a random gap, and records its result.
   task automatic send_op(
      input logic [KIND_W-1:0]               kind,
      input logic signed [OPERAND_WIDTH-1:0] a_num,
      input logic [DEN_W-1:0]                a_den,
      input logic signed [OPERAND_WIDTH-1:0] b_num,
      input logic [DEN_W-1:0]                b_den);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = ($urandom_range(3) == 0) ? $urandom_range(90, 10) : $urandom_range(6, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_a_num <= a_num;
      req_a_den <= a_den;
      req_b_num <= b_num;
      req_b_den <= b_den;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(rational_result(kind, a_num, a_den, b_num, b_den));
   endtask

   // Sends one random operation; sometimes the right operand equals the left.
   task automatic send_random_op();
      logic [KIND_W-1:0]               kind;
      logic signed [OPERAND_WIDTH-1:0] a_num, b_num;
      logic [DEN_W-1:0]                a_den, b_den;
      if ($urandom_range(19) == 0)
         kind = KIND_W'($urandom_range(KIND_LAST, KIND_NE + 1));
      else
         kind = KIND_W'($urandom_range(KIND_NE));
      a_num = pick_num();
      a_den = pick_den();
      b_num = pick_num();
      b_den = pick_den();
      if ($urandom_range(7) == 0) begin
         b_num = a_num;
         b_den = a_den;
      end
      send_op(kind, a_num, a_den, b_num, b_den);
   endtask

   // Drops the request and waits until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Arithmetic corners: extremes, zero results, division by zero and
   // zero input denominators.
   task automatic test_arithmetic_corners();
      send_op(KIND_ADD, 16'sd1, 15'd2, 16'sd1, 15'd3);
      send_op(KIND_ADD, 16'sd32767, 15'd1, 16'sd32767, 15'd1);
      send_op(KIND_ADD, -16'sd32768, 15'd32767, -16'sd32768, 15'd32767);
      send_op(KIND_SUB, 16'sd1, 15'd2, 16'sd2, 15'd4);
      send_op(KIND_SUB, -16'sd32768, 15'd1, 16'sd32767, 15'd32767);
      send_op(KIND_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1);
      send_op(KIND_MUL, 16'sd6, 15'd32767, 16'sd0, 15'd5);
      send_op(KIND_DIV, 16'sd3, 15'd4, 16'sd0, 15'd5);
      send_op(KIND_DIV, 16'sd1, 15'd2, -16'sd3, 15'd4);
      send_op(KIND_DIV, 16'sd0, 15'd7, -16'sd9, 15'd2);
      send_op(KIND_NEG, -16'sd32768, 15'd32767, 16'sd0, 15'd0);
      send_op(KIND_NEG, 16'sd0, 15'd7, 16'sd5, 15'd1);
      send_op(KIND_ADD, 16'sd5, 15'd0, 16'sd3, 15'd4);
      send_op(KIND_MUL, 16'sd5, 15'd3, 16'sd3, 15'd0);
      drain_results();
   endtask

   // Each comparison on an equal pair and on an unequal pair at the extremes.
   task automatic test_comparison_corners();
      logic [KIND_W-1:0] kind;
      for (int k = KIND_LT; k <= KIND_NE; k++) begin
         kind = KIND_W'(k);
         send_op(kind, 16'sd1, 15'd2, 16'sd2, 15'd4);
         send_op(kind, -16'sd32768, 15'd32767, 16'sd32767, 15'd1);
      end
      drain_results();
   endtask

   // Unused codes, and a comparison with a zero denominator.
   task automatic test_unused_codes();
      send_op(KIND_W'(KIND_NE + 1), 16'sd7, 15'd3, 16'sd1, 15'd1);
      send_op(KIND_LAST, -16'sd1, 15'd32767, -16'sd32768, 15'd0);
      send_op(KIND_LT, 16'sd4, 15'd0, 16'sd3, 15'd2);
      drain_results();
   endtask

   // A batch of random operations under one pattern of gaps and stalls.
   task automatic test_random_mix(input int count, input int send_idle, input int recv_stall);
      send_idle_pct = send_idle;
      stall_pct    <= recv_stall;
      repeat (count) send_random_op();
      drain_results();
   endtask

   // The receiver holds off while the sender keeps offering, so the block
   // fills up and stalls its request channel.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct    <= 0;
      hold_req     <= ~hold_req;
      repeat (12) send_random_op();
      drain_results();
   endtask

   // Receiver stall: random per cycle, or a long hold when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 1'b0;
         hold_left <= 0;
      end else if (hold_req != hold_seen) begin
         rsp_stall <= 1'b1;
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Checks each accepted response against the oldest expected result.
   always @(posedge clock) begin
      rational_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: response with no transaction pending, actual %0d/%0d cmp %0b err %0b",
                     $time, rsp_res_num, rsp_res_den, rsp_cmp_true, rsp_error);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_num !== want.num) begin
               $display("%0t ns: res_num expected %0d, actual %0d", $time, want.num, rsp_res_num);
               mismatch_count++;
            end
            if (rsp_res_den !== want.den) begin
               $display("%0t ns: res_den expected %0d, actual %0d", $time, want.den, rsp_res_den);
               mismatch_count++;
            end
            if (rsp_cmp_true !== want.cmp) begin
               $display("%0t ns: cmp_true expected %0b, actual %0b", $time, want.cmp, rsp_cmp_true);
               mismatch_count++;
            end
            if (rsp_error !== want.err) begin
               $display("%0t ns: error expected %0b, actual %0b", $time, want.err, rsp_error);
               mismatch_count++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_arithmetic_corners();
      test_comparison_corners();
      test_unused_codes();
      test_random_mix(280, 0, 0);
      test_random_mix(280, 50, 0);
      test_output_backpressure();
      test_random_mix(280, 0, 50);
      test_random_mix(280, 35, 35);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("rational_arithmetic_unit_top verification clean");
      else
         $display("rational_arithmetic_unit_top verification failed");
      $finish;
   end

   // Watchdog, several times the slowest expected run.
   initial begin
      #10_000_000;
      $display("rational_arithmetic_unit_top verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit_top.sv
sim/tb.sv
